// File: hw/rtl/smc_kpi_pkg.sv
package smc_kpi_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned VALUE_BYTES_DEF   = 32;
  localparam int unsigned RECEIVE_BYTES_DEF = 64;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ENT_W  = 6;
  localparam int unsigned OFF_W  = 5;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SIZE_W = 6;
  localparam int unsigned CNT_W  = 9;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD     = 1'd1;

  localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RDATA    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WCMD     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WDATA    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOAD_HDR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LOAD_VAL = 3'd5;

  localparam logic [BYTE_W-1:0] OP_READ     = 8'h10;
  localparam logic [BYTE_W-1:0] OP_WRITE    = 8'h11;
  localparam logic [BYTE_W-1:0] OP_BY_INDEX = 8'h12;
  localparam logic [BYTE_W-1:0] OP_INFO     = 8'h13;

  localparam logic [BYTE_W-1:0] ST_READY = 8'h01;
  localparam logic [BYTE_W-1:0] ST_BUSY  = 8'h04;
  localparam int unsigned ATTR_WR_BIT = 6;

  localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [CNT_W-1:0] ARG_BYTES = 9'd5;
  localparam logic [CNT_W-1:0] KEY_BYTES = 9'd4;

  typedef struct packed {
    logic accept;
    logic reply;
    logic search;
    logic fetch;
    logic eval;
    logic copy;
    logic wcopy;
  } kpi_cmd_t;

  typedef struct packed {
    logic go_reply;
    logic go_search;
    logic go_fetch;
    logic srch_hit;
    logic srch_miss;
    logic eval_copy;
    logic eval_wcopy;
    logic copy_done;
  } kpi_status_t;

endpackage

// File: hw/rtl/smc_kpi_in_if.sv
interface smc_kpi_in_if;
  import smc_kpi_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [BYTE_W-1:0]   data_byte;
  logic [ENT_W-1:0]    entry_index;
  logic [OFF_W-1:0]    byte_offset;
  logic [WORD_W-1:0]   key_name;
  logic [WORD_W-1:0]   key_type;
  logic [BYTE_W-1:0]   key_attributes;
  logic [SIZE_W-1:0]   key_size;

  modport source (output valid, command, data_byte, entry_index, byte_offset, key_name,
                  key_type, key_attributes, key_size, input ready);
  modport sink (input valid, command, data_byte, entry_index, byte_offset, key_name,
                key_type, key_attributes, key_size, output ready);
endinterface

// File: hw/rtl/smc_kpi_out_if.sv
interface smc_kpi_out_if;
  import smc_kpi_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: hw/rtl/smc_kpi_ctl.sv
module smc_kpi_ctl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  smc_kpi_pkg::kpi_status_t  status,
  output smc_kpi_pkg::kpi_cmd_t     cmd
);
  import smc_kpi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_REPLY, S_SEARCH, S_FETCH, S_EVAL, S_COPY, S_WCOPY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    cmd.reply  = (state_r == S_REPLY);
    cmd.search = (state_r == S_SEARCH);
    cmd.fetch  = (state_r == S_FETCH);
    cmd.eval   = (state_r == S_EVAL);
    cmd.copy   = (state_r == S_COPY);
    cmd.wcopy  = (state_r == S_WCOPY);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = !status.go_reply;
          if (status.go_reply) state_nxt = S_REPLY;
          else if (status.go_search) state_nxt = S_SEARCH;
          else if (status.go_fetch) state_nxt = S_FETCH;
        end
      end
      S_REPLY: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SEARCH: begin
        if (status.srch_hit) state_nxt = S_FETCH;
        else if (status.srch_miss) state_nxt = S_IDLE;
      end
      S_FETCH: state_nxt = S_EVAL;
      S_EVAL: begin
        if (status.eval_copy) state_nxt = S_COPY;
        else if (status.eval_wcopy) state_nxt = S_WCOPY;
        else state_nxt = S_IDLE;
      end
      S_COPY, S_WCOPY: begin
        if (status.copy_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// File: hw/rtl/smc_kpi_dp.sv
module smc_kpi_dp #(
  parameter int unsigned TABLE_ENTRIES = smc_kpi_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned VALUE_BYTES   = smc_kpi_pkg::VALUE_BYTES_DEF,
  parameter int unsigned RECEIVE_BYTES = smc_kpi_pkg::RECEIVE_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [smc_kpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smc_kpi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [smc_kpi_pkg::CMD_W-1:0]        command,
  input  logic [smc_kpi_pkg::BYTE_W-1:0]       data_byte,
  input  logic [smc_kpi_pkg::ENT_W-1:0]        entry_index,
  input  logic [smc_kpi_pkg::OFF_W-1:0]        byte_offset,
  input  logic [smc_kpi_pkg::WORD_W-1:0]       key_name,
  input  logic [smc_kpi_pkg::WORD_W-1:0]       key_type,
  input  logic [smc_kpi_pkg::BYTE_W-1:0]       key_attributes,
  input  logic [smc_kpi_pkg::SIZE_W-1:0]       key_size,
  input  smc_kpi_pkg::kpi_cmd_t                cmd,
  output smc_kpi_pkg::kpi_status_t             status,
  output logic [smc_kpi_pkg::BYTE_W-1:0]       read_data
);
  import smc_kpi_pkg::*;

  localparam int unsigned REPLY_CAP = VALUE_BYTES + 8;
  localparam int unsigned TI_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned LIVE_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned VA_W   = $clog2(TABLE_ENTRIES * VALUE_BYTES);
  localparam int unsigned RA_W   = $clog2(RECEIVE_BYTES);
  localparam int unsigned PA_W   = $clog2(REPLY_CAP);
  localparam int unsigned RL_W   = $clog2(REPLY_CAP + 1);
  localparam int unsigned INF_W  = 6 * BYTE_W;

  logic [WORD_W-1:0] name_mem  [TABLE_ENTRIES];
  logic [WORD_W-1:0] type_mem  [TABLE_ENTRIES];
  logic [BYTE_W-1:0] attr_mem  [TABLE_ENTRIES];
  logic [SIZE_W-1:0] size_mem  [TABLE_ENTRIES];
  logic [BYTE_W-1:0] value_mem [TABLE_ENTRIES * VALUE_BYTES];
  logic [BYTE_W-1:0] recv_mem  [RECEIVE_BYTES];
  logic [BYTE_W-1:0] reply_mem [REPLY_CAP];

  logic [CFG_DATA_W-1:0] keys_r;
  logic                  discard_r;
  logic [BYTE_W-1:0]     act_r;
  logic [BYTE_W-1:0]     req_len_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [WORD_W-1:0]     key_r;
  logic [RL_W-1:0]       rep_len_r;
  logic [RL_W-1:0]       pos_r;
  logic                  awaiting_r;
  logic                  busy_r;
  logic [LIVE_W-1:0]     sidx_r;
  logic [TI_W-1:0]       cidx_r;
  logic                  cvld_r;
  logic [TI_W-1:0]       kidx_r;
  logic [RL_W-1:0]       cpj_r;
  logic [PA_W-1:0]       cpi_r;
  logic                  cpv_r;
  logic [RL_W-1:0]       cp_len_r;
  logic [INF_W-1:0]      inf_r;
  logic [WORD_W-1:0]     name_rd_r;
  logic [WORD_W-1:0]     type_rd_r;
  logic [BYTE_W-1:0]     attr_rd_r;
  logic [SIZE_W-1:0]     size_rd_r;
  logic [BYTE_W-1:0]     value_rd_r;
  logic [BYTE_W-1:0]     recv_rd_r;
  logic [BYTE_W-1:0]     reply_rd_r;
  logic [BYTE_W-1:0]     read_data_r;

  logic [LIVE_W-1:0] live;
  logic [CNT_W-1:0]  cnt_inc;
  logic              dat, disp, wend, ent_ok, off_ok;
  logic [TI_W-1:0]   name_addr;
  logic [TI_W-1:0]   ent_addr;
  logic [VA_W-1:0]   load_va, copy_va, wcopy_va;
  logic [RA_W-1:0]   recv_ra;
  logic [BYTE_W-1:0] status_byte;
  logic              search_more;
  logic [SIZE_W-1:0] size_sat;

  assign live = (32'(keys_r) > TABLE_ENTRIES) ? LIVE_W'(TABLE_ENTRIES) : LIVE_W'(keys_r);
  assign cnt_inc = (cnt_r < COUNT_MAX) ? cnt_r + 9'd1 : cnt_r;
  assign dat  = cmd.accept && (command == CMD_WDATA) && busy_r;
  assign disp = dat && (cnt_inc == ARG_BYTES);
  assign wend = dat && !disp && (act_r == OP_WRITE) && (cnt_inc == ARG_BYTES + {1'b0, req_len_r});
  assign ent_ok = 32'(entry_index) < TABLE_ENTRIES;
  assign off_ok = 32'(byte_offset) < VALUE_BYTES;
  assign ent_addr = TI_W'(entry_index);
  assign load_va  = VA_W'(32'(entry_index) * VALUE_BYTES + 32'(byte_offset));
  assign copy_va  = VA_W'(32'(kidx_r) * VALUE_BYTES + 32'(cpj_r));
  assign wcopy_va = VA_W'(32'(kidx_r) * VALUE_BYTES + 32'(cpi_r));
  assign recv_ra  = RA_W'(32'(cpj_r) + 32'(ARG_BYTES));
  assign name_addr = cmd.search ? TI_W'(sidx_r) : kidx_r;
  assign search_more = sidx_r < live;
  assign size_sat = (32'(key_size) > VALUE_BYTES) ? SIZE_W'(VALUE_BYTES) : key_size;
  assign status_byte = (awaiting_r ? ST_READY : '0) | (busy_r ? ST_BUSY : '0);
  assign read_data = read_data_r;

  always_comb begin
    status = '0;
    status.go_reply  = (command == CMD_RDATA) && (pos_r < rep_len_r);
    status.go_search = (disp && ((act_r == OP_READ) || (act_r == OP_INFO))) ||
                       (wend && !discard_r);
    status.go_fetch  = disp && (act_r == OP_BY_INDEX) && (key_r < 32'(live));
    status.srch_hit  = cvld_r && (name_rd_r == key_r);
    status.srch_miss = !cvld_r && !search_more;
    status.eval_copy = (act_r == OP_READ) ? (size_rd_r != '0) :
                       ((act_r == OP_INFO) || (act_r == OP_BY_INDEX));
    status.eval_wcopy = (act_r == OP_WRITE) && attr_rd_r[ATTR_WR_BIT] &&
                        ({2'b0, size_rd_r} == req_len_r);
    status.copy_done = !cpv_r && (cpj_r >= cp_len_r);
  end

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.accept && (command == CMD_LOAD_HDR) && ent_ok) begin
      name_mem[ent_addr] <= key_name;
      type_mem[ent_addr] <= key_type;
      attr_mem[ent_addr] <= key_attributes;
      size_mem[ent_addr] <= size_sat;
    end
    name_rd_r <= name_mem[name_addr];
    type_rd_r <= type_mem[kidx_r];
    attr_rd_r <= attr_mem[kidx_r];
    size_rd_r <= size_mem[kidx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (command == CMD_LOAD_VAL) && ent_ok && off_ok) begin
      value_mem[load_va] <= data_byte;
    end else if (cmd.wcopy && cpv_r) begin
      value_mem[wcopy_va] <= recv_rd_r;
    end
    value_rd_r <= value_mem[copy_va];
  end

  always_ff @(posedge clk) begin
    if (dat && (32'(cnt_r) < RECEIVE_BYTES)) begin
      recv_mem[RA_W'(cnt_r)] <= data_byte;
    end
    recv_rd_r <= recv_mem[recv_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy && cpv_r) begin
      reply_mem[cpi_r] <= (act_r == OP_READ) ? value_rd_r : inf_r[INF_W-1 -: BYTE_W];
    end
    reply_rd_r <= reply_mem[PA_W'(pos_r)];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      read_data_r <= (command == CMD_STATUS) ? status_byte : '0;
    end else if (cmd.reply) begin
      read_data_r <= reply_rd_r;
    end
    if (dat && (cnt_r < KEY_BYTES)) key_r <= {key_r[WORD_W-BYTE_W-1:0], data_byte};
    if (cmd.eval) begin
      if (act_r == OP_INFO) inf_r <= {2'b0, size_rd_r, type_rd_r, attr_rd_r};
      else inf_r <= {name_rd_r, 16'h0};
    end else if (cmd.copy && cpv_r) begin
      inf_r <= {inf_r[INF_W-BYTE_W-1:0], 8'h0};
    end
  end

  // transaction and sequencing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r     <= '0;
      discard_r  <= 1'b0;
      act_r      <= '0;
      req_len_r  <= '0;
      cnt_r      <= '0;
      rep_len_r  <= '0;
      pos_r      <= '0;
      awaiting_r <= 1'b0;
      busy_r     <= 1'b0;
      sidx_r     <= '0;
      cidx_r     <= '0;
      cvld_r     <= 1'b0;
      kidx_r     <= '0;
      cpj_r      <= '0;
      cpi_r      <= '0;
      cpv_r      <= 1'b0;
      cp_len_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEYS_IN_USE: keys_r <= cfg_data;
          CFG_DISCARD:     discard_r <= cfg_data[0];
          default:         ;
        endcase
      end
      if (cmd.accept) begin
        if ((command == CMD_RDATA) && status.go_reply) begin
          pos_r <= pos_r + 1'b1;
          if (pos_r + 1'b1 >= rep_len_r) begin
            awaiting_r <= 1'b0;
            busy_r     <= 1'b0;
          end
        end
        if (command == CMD_WCMD) begin
          act_r      <= data_byte;
          cnt_r      <= '0;
          rep_len_r  <= '0;
          pos_r      <= '0;
          awaiting_r <= 1'b0;
          busy_r     <= 1'b1;
        end
        if (dat) cnt_r <= cnt_inc;
        if (disp) begin
          req_len_r <= data_byte;
          case (act_r)
            OP_READ, OP_INFO: ;
            OP_BY_INDEX: begin
              kidx_r <= TI_W'(key_r);
              if (!status.go_fetch) begin
                awaiting_r <= 1'b0;
                busy_r     <= 1'b0;
                rep_len_r  <= '0;
                pos_r      <= '0;
              end
            end
            OP_WRITE: begin
              awaiting_r <= 1'b0;
              busy_r     <= (data_byte != '0);
            end
            default: begin
              awaiting_r <= 1'b0;
              busy_r     <= 1'b0;
              rep_len_r  <= '0;
              pos_r      <= '0;
            end
          endcase
        end
        if (wend && discard_r) begin
          awaiting_r <= 1'b0;
          busy_r     <= 1'b0;
          rep_len_r  <= '0;
          pos_r      <= '0;
        end
        if (status.go_search) begin
          sidx_r <= '0;
          cvld_r <= 1'b0;
        end
      end
      if (cmd.search) begin
        if (status.srch_hit) begin
          kidx_r <= cidx_r;
        end else if (search_more) begin
          cidx_r <= TI_W'(sidx_r);
          cvld_r <= 1'b1;
          sidx_r <= sidx_r + 1'b1;
        end else begin
          cvld_r <= 1'b0;
          if (status.srch_miss) begin
            awaiting_r <= 1'b0;
            busy_r     <= 1'b0;
            rep_len_r  <= '0;
            pos_r      <= '0;
          end
        end
      end
      if (cmd.eval) begin
        cpj_r <= '0;
        cpv_r <= 1'b0;
        if (act_r == OP_INFO) cp_len_r <= RL_W'(6);
        else if (act_r == OP_BY_INDEX) cp_len_r <= RL_W'(4);
        else cp_len_r <= RL_W'(size_rd_r);
        if (!status.eval_copy && !status.eval_wcopy) begin
          awaiting_r <= 1'b0;
          busy_r     <= 1'b0;
          rep_len_r  <= '0;
          pos_r      <= '0;
        end
      end
      if (cmd.copy || cmd.wcopy) begin
        if (cpj_r < cp_len_r) begin
          cpi_r <= PA_W'(cpj_r);
          cpv_r <= 1'b1;
          cpj_r <= cpj_r + 1'b1;
        end else begin
          cpv_r <= 1'b0;
        end
        if (status.copy_done) begin
          pos_r <= '0;
          if (cmd.copy) begin
            rep_len_r  <= cp_len_r;
            awaiting_r <= 1'b1;
            busy_r     <= 1'b1;
          end else begin
            rep_len_r  <= '0;
            awaiting_r <= 1'b0;
            busy_r     <= 1'b0;
          end
        end
      end
    end
  end
endmodule

// File: hw/rtl/smc_key_port_interface_top.sv
// an accepted access gives its registered result in the cycle after acceptance, and a
// data-port read of a reply byte passes through the reply state first; a fifth data byte
// that opens a lookup, or the last byte of a write with discard off, gives its result, but
// the next waits for the linear search of live entries, table fetch, evaluation and copy
// one transaction at a time; the next is taken once the result has left
// synchronous active-low reset clears control state; the key table is undefined until loaded
module smc_key_port_interface_top #(
  parameter int unsigned TABLE_ENTRIES = smc_kpi_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned VALUE_BYTES   = smc_kpi_pkg::VALUE_BYTES_DEF,
  parameter int unsigned RECEIVE_BYTES = smc_kpi_pkg::RECEIVE_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [smc_kpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smc_kpi_pkg::CFG_DATA_W-1:0] cfg_data,
  smc_kpi_in_if.sink                         in_if,
  smc_kpi_out_if.source                      out_if
);
  import smc_kpi_pkg::*;

  kpi_cmd_t    cmd;
  kpi_status_t status;

  smc_kpi_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  smc_kpi_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .VALUE_BYTES   (VALUE_BYTES),
    .RECEIVE_BYTES (RECEIVE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (in_if.command),
    .data_byte      (in_if.data_byte),
    .entry_index    (in_if.entry_index),
    .byte_offset    (in_if.byte_offset),
    .key_name       (in_if.key_name),
    .key_type       (in_if.key_type),
    .key_attributes (in_if.key_attributes),
    .key_size       (in_if.key_size),
    .cmd            (cmd),
    .status         (status),
    .read_data      (out_if.read_data)
  );
endmodule

// File: tb/sv/tb_smc_key_port_interface_top.sv
`timescale 1ns / 1ps

module tb_smc_key_port_interface_top;
  import smc_kpi_pkg::*;

  localparam int unsigned N_ENT = TABLE_ENTRIES_DEF;
  localparam int unsigned N_VAL = VALUE_BYTES_DEF;
  localparam int unsigned N_RX  = RECEIVE_BYTES_DEF;
  localparam int unsigned REPLY_MAX = VALUE_BYTES_DEF + 8;
  localparam logic [BYTE_W-1:0] OP_UNKNOWN = 8'h7E;
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    logic [ENT_W-1:0]  ent;
    logic [OFF_W-1:0]  off;
    logic [WORD_W-1:0] kname;
    logic [WORD_W-1:0] ktype;
    logic [BYTE_W-1:0] kattr;
    logic [SIZE_W-1:0] ksize;
    bit                fixed;
    logic [BYTE_W-1:0] fixed_val;
  } port_access_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  smc_kpi_in_if in_if ();
  smc_kpi_out_if out_if ();

  smc_key_port_interface_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_if    (in_if.sink),
    .out_if   (out_if.source)
  );

  always #5 clk = ~clk;

  // model of the controller
  bit [31:0] m_name[N_ENT];
  bit [31:0] m_type[N_ENT];
  bit [7:0]  m_attr[N_ENT];
  bit [5:0]  m_size[N_ENT];
  bit [7:0]  m_val[N_ENT][N_VAL];
  bit [7:0]  m_op = '0;
  bit [7:0]  m_req_len = '0;
  bit [7:0]  m_rx[N_RX];
  int unsigned m_rx_cnt = 0;
  bit [7:0]  m_reply[REPLY_MAX];
  int unsigned m_rep_len = 0;
  int unsigned m_rep_pos = 0;
  bit m_awaiting = 1'b0;
  bit m_busy = 1'b0;
  int unsigned m_keys = 0;
  bit m_discard = 1'b0;

  // generator-side copy of the key table
  bit [31:0] g_name[N_ENT];
  bit [5:0]  g_size[N_ENT];
  // value bytes loaded from offset zero per entry
  int unsigned g_vlen[N_ENT];

  logic [BYTE_W-1:0] read_data_q[$];
  bit [BYTE_W-1:0] fixed_q[$];
  bit fixed_flag_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  bit calm = 1'b0;
  bit drv_fixed = 1'b0;
  logic [BYTE_W-1:0] drv_fixed_val = '0;

  function automatic int unsigned live_keys();
    return (m_keys < N_ENT) ? m_keys : N_ENT;
  endfunction

  function automatic bit [31:0] key_word();
    return {m_rx[0], m_rx[1], m_rx[2], m_rx[3]};
  endfunction

  function automatic int find_key(bit [31:0] nm);
    for (int i = 0; i < live_keys(); i++)
      if (m_name[i] == nm) return i;
    return -1;
  endfunction

  function automatic void close_txn();
    m_awaiting = 1'b0;
    m_busy = 1'b0;
    m_rep_len = 0;
    m_rep_pos = 0;
  endfunction

  function automatic void open_reply(int unsigned len);
    m_rep_len = len;
    m_rep_pos = 0;
    m_awaiting = 1'b1;
    m_busy = 1'b1;
  endfunction

  function automatic void start_op(bit [7:0] len);
    int k;
    bit [31:0] idx;
    m_req_len = len;
    case (m_op)
      OP_READ: begin
        k = find_key(key_word());
        if (k >= 0 && m_size[k] > 0) begin
          for (int i = 0; i < m_size[k]; i++) m_reply[i] = m_val[k][i];
          open_reply(m_size[k]);
        end else close_txn();
      end
      OP_INFO: begin
        k = find_key(key_word());
        if (k >= 0) begin
          m_reply[0] = 8'(m_size[k]);
          {m_reply[1], m_reply[2], m_reply[3], m_reply[4]} = m_type[k];
          m_reply[5] = m_attr[k];
          open_reply(6);
        end else close_txn();
      end
      OP_BY_INDEX: begin
        idx = key_word();
        if (idx < live_keys()) begin
          {m_reply[0], m_reply[1], m_reply[2], m_reply[3]} = m_name[idx];
          open_reply(4);
        end else close_txn();
      end
      OP_WRITE: begin
        m_awaiting = 1'b0;
        m_busy = (len != 0);
      end
      default: close_txn();
    endcase
  endfunction

  function automatic void take_data_byte(bit [7:0] b);
    int k;
    if (!m_busy) return;
    if (m_rx_cnt < N_RX) m_rx[m_rx_cnt] = b;
    if (m_rx_cnt < COUNT_MAX) m_rx_cnt++;
    if (m_rx_cnt == ARG_BYTES) begin
      start_op(m_rx[4]);
      return;
    end
    if (m_op == OP_WRITE && m_rx_cnt == ARG_BYTES + m_req_len) begin
      if (!m_discard) begin
        k = find_key(key_word());
        if (k >= 0 && m_attr[k][ATTR_WR_BIT] && m_size[k] == m_req_len)
          for (int i = 0; i < m_req_len; i++) m_val[k][i] = m_rx[5 + i];
      end
      close_txn();
    end
  endfunction

  function automatic bit [7:0] port_access(port_access_t a);
    bit [7:0] r;
    r = '0;
    case (a.cmd)
      CMD_STATUS: r = (m_awaiting ? ST_READY : 8'h00) | (m_busy ? ST_BUSY : 8'h00);
      CMD_RDATA: begin
        if (m_rep_pos < m_rep_len && m_rep_pos < REPLY_MAX) begin
          r = m_reply[m_rep_pos];
          m_rep_pos++;
          if (m_rep_pos >= m_rep_len) begin
            m_awaiting = 1'b0;
            m_busy = 1'b0;
          end
        end
      end
      CMD_WCMD: begin
        m_op = a.data;
        m_rx_cnt = 0;
        m_rep_len = 0;
        m_rep_pos = 0;
        m_awaiting = 1'b0;
        m_busy = 1'b1;
      end
      CMD_WDATA: take_data_byte(a.data);
      CMD_LOAD_HDR: begin
        m_name[a.ent] = a.kname;
        m_type[a.ent] = a.ktype;
        m_attr[a.ent] = a.kattr;
        m_size[a.ent] = (a.ksize > N_VAL) ? 6'(N_VAL) : a.ksize;
      end
      CMD_LOAD_VAL: m_val[a.ent][a.off] = a.data;
      default: ;
    endcase
    return r;
  endfunction

  // acceptance monitor and result checker
  always @(posedge clk) begin
    port_access_t a;
    bit [7:0] exp_val;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        a.cmd = in_if.command;
        a.data = in_if.data_byte;
        a.ent = in_if.entry_index;
        a.off = in_if.byte_offset;
        a.kname = in_if.key_name;
        a.ktype = in_if.key_type;
        a.kattr = in_if.key_attributes;
        a.ksize = in_if.key_size;
        exp_val = port_access(a);
        read_data_q.push_back(drv_fixed ? drv_fixed_val : exp_val);
      end
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (read_data_q.size() == 0) begin
          $error("read_data: unexpected transaction, actual %0h", out_if.read_data);
          errors++;
        end else begin
          exp_val = read_data_q.pop_front();
          if (out_if.read_data !== exp_val) begin
            $error("read_data: expected %0h actual %0h", exp_val, out_if.read_data);
            errors++;
          end
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int hold;
    bit held;
    held = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && n_results >= 500) begin
        held = 1'b1;
        out_if.ready = 1'b0;
        hold = 0;
        while (hold < 300) begin
          @(negedge clk);
          hold++;
        end
      end
      out_if.ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic send(port_access_t a);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.command = a.cmd;
    in_if.data_byte = a.data;
    in_if.entry_index = a.ent;
    in_if.byte_offset = a.off;
    in_if.key_name = a.kname;
    in_if.key_type = a.ktype;
    in_if.key_attributes = a.kattr;
    in_if.key_size = a.ksize;
    drv_fixed = a.fixed;
    drv_fixed_val = a.fixed_val;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    n_sent++;
    calm = (n_sent >= 600 && n_sent < 800);
  endtask

  function automatic port_access_t mk(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
    port_access_t a;
    a = '{cmd: cmd, data: data, ent: ENT_W'($urandom), off: OFF_W'($urandom),
          kname: $urandom, ktype: $urandom, kattr: BYTE_W'($urandom),
          ksize: SIZE_W'($urandom_range(0, 32)), fixed: 1'b0, fixed_val: '0};
    return a;
  endfunction

  task automatic load_header(int e, bit [31:0] nm, bit [31:0] ty, bit [7:0] at, bit [5:0] sz);
    port_access_t a;
    a = mk(CMD_LOAD_HDR, 8'($urandom));
    a.ent = ENT_W'(e);
    a.kname = nm;
    a.ktype = ty;
    a.kattr = at;
    a.ksize = sz;
    g_name[e] = nm;
    g_size[e] = (sz > N_VAL) ? 6'(N_VAL) : sz;
    send(a);
  endtask

  task automatic load_value(int e, int o, bit [7:0] b);
    port_access_t a;
    a = mk(CMD_LOAD_VAL, b);
    a.ent = ENT_W'(e);
    a.off = OFF_W'(o);
    send(a);
  endtask

  task automatic quiesce();
    int guard;
    @(negedge clk);
    in_if.valid = 1'b0;
    drv_fixed = 1'b0;
    guard = 0;
    while (read_data_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(val);
    if (idx == CFG_KEYS_IN_USE) m_keys = val;
    else m_discard = val[0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_txn();
    int sel;
    int e;
    int len;
    int nreads;
    bit [7:0] op;
    bit [31:0] arg;
    port_access_t a;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      case ($urandom_range(0, 3))
        0: begin
          e = $urandom_range(0, N_ENT - 1);
          load_header(e, ($urandom_range(0, 2) == 0) ? g_name[$urandom_range(0, N_ENT - 1)]
                                                     : $urandom,
                      $urandom, 8'($urandom),
                      (g_vlen[e] == N_VAL) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, g_vlen[e])));
        end
        1: load_value($urandom_range(0, N_ENT - 1), $urandom_range(0, N_VAL - 1),
                      8'($urandom));
        default: begin
          a = mk(CMD_W'($urandom_range(0, 7)), 8'($urandom));
          if (a.cmd == CMD_LOAD_HDR) begin
            a.ksize = SIZE_W'($urandom_range(0, g_vlen[a.ent]));
            g_name[a.ent] = a.kname;
            g_size[a.ent] = a.ksize;
          end
          send(a);
        end
      endcase
      return;
    end
    if (sel < 42) op = OP_READ;
    else if (sel < 56) op = OP_INFO;
    else if (sel < 70) op = OP_BY_INDEX;
    else if (sel < 93) op = OP_WRITE;
    else op = ($urandom_range(0, 1) == 0) ? OP_UNKNOWN : 8'($urandom);
    e = $urandom_range(0, N_ENT - 1);
    if (op == OP_BY_INDEX)
      arg = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 70) : $urandom;
    else
      arg = ($urandom_range(0, 99) < 85) ? g_name[e] : $urandom;
    if (op == OP_WRITE) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = $urandom_range(0, 70);
        2, 3: len = $urandom_range(1, 40);
        default: len = g_size[e];
      endcase
    end else len = $urandom;
    send(mk(CMD_WCMD, op));
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 99) < 3) return;
      send(mk(CMD_WDATA, arg[31 - 8 * i -: 8]));
    end
    send(mk(CMD_WDATA, 8'(len)));
    if (op == OP_WRITE) begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 199) == 0) return;
        send(mk(CMD_WDATA, 8'($urandom)));
      end
      nreads = 0;
    end else if (op == OP_READ) nreads = g_size[e];
    else if (op == OP_INFO) nreads = 6;
    else nreads = 4;
    send(mk(CMD_STATUS, 8'($urandom)));
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) send(mk(CMD_WDATA, 8'($urandom)));
    nreads = nreads + $urandom_range(0, 2) - $urandom_range(0, 1);
    for (int i = 0; i < nreads; i++) send(mk(CMD_RDATA, 8'($urandom)));
    send(mk(CMD_STATUS, 8'($urandom)));
  endtask

  port_access_t directed[$];

  task automatic add_row(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data, bit fixed,
                         logic [BYTE_W-1:0] val);
    port_access_t a;
    a = mk(cmd, data);
    a.fixed = fixed;
    a.fixed_val = val;
    directed.push_back(a);
  endtask

  initial begin
    port_access_t a;
    int unsigned keys_set[6];
    bit disc_set[6];
    in_if.valid = 1'b0;
    in_if.command = CMD_STATUS;
    in_if.data_byte = '0;
    in_if.entry_index = '0;
    in_if.byte_offset = '0;
    in_if.key_name = '0;
    in_if.key_type = '0;
    in_if.key_attributes = '0;
    in_if.key_size = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // after reset: idle port reads and ignored commands
    add_row(CMD_STATUS, 8'hFF, 1'b1, 8'h00);
    add_row(CMD_RDATA, 8'h00, 1'b1, 8'h00);
    add_row(CMD_UNUSED_A, 8'hFF, 1'b1, 8'h00);
    add_row(CMD_UNUSED_B, 8'hA5, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h5A, 1'b1, 8'h00);
    add_row(CMD_STATUS, 8'h00, 1'b1, 8'h00);
    foreach (directed[i]) send(directed[i]);
    directed.delete();
    a = mk(CMD_LOAD_HDR, 8'hFF);
    a.ent = ENT_W'(N_ENT - 1);
    a.kname = '1;
    a.ktype = '1;
    a.kattr = '1;
    a.ksize = 6'd63;
    a.fixed = 1'b1;
    send(a);
    a = mk(CMD_LOAD_VAL, 8'hFF);
    a.ent = ENT_W'(N_ENT - 1);
    a.off = OFF_W'(N_VAL - 1);
    a.fixed = 1'b1;
    send(a);

    // fill the whole table, full values only for the first entries
    for (int e = 0; e < N_ENT; e++) begin
      g_vlen[e] = (e < 3) ? N_VAL : 4;
      load_header(e, (e == 10) ? 32'h4B055F30 : {8'h4B, 8'(e), 16'h5F30}, $urandom,
                  (e == 2) ? 8'hC0 : 8'($urandom),
                  (e == 3) ? 6'd0 : ((e < 3) ? 6'(N_VAL) : 6'((e % 4) + 1)));
      for (int o = 0; o < g_vlen[e]; o++) load_value(e, o, 8'($urandom));
    end
    quiesce();
    write_reg(CFG_KEYS_IN_USE, 64);
    write_reg(CFG_DISCARD, 0);

    // read a key, index past the table, zero-length write
    add_row(CMD_WCMD, OP_READ, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h4B, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h01, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h5F, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h30, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h00, 1'b1, 8'h00);
    add_row(CMD_STATUS, 8'h00, 1'b1, ST_READY | ST_BUSY);
    add_row(CMD_RDATA, 8'h00, 1'b0, 8'h00);
    add_row(CMD_RDATA, 8'h00, 1'b0, 8'h00);
    add_row(CMD_WCMD, OP_BY_INDEX, 1'b1, 8'h00);
    repeat (4) add_row(CMD_WDATA, 8'hFF, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h04, 1'b1, 8'h00);
    add_row(CMD_STATUS, 8'h00, 1'b1, 8'h00);
    add_row(CMD_WCMD, OP_WRITE, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h4B, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h02, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h5F, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h30, 1'b1, 8'h00);
    add_row(CMD_WDATA, 8'h00, 1'b1, 8'h00);
    add_row(CMD_STATUS, 8'h00, 1'b1, 8'h00);
    foreach (directed[i]) send(directed[i]);

    keys_set = '{64, 64, 0, 127, 1, $urandom_range(0, 127)};
    disc_set = '{0, 1, 0, 0, 1, $urandom_range(0, 1)};
    for (int p = 0; p < 6; p++) begin
      int start;
      quiesce();
      write_reg(CFG_KEYS_IN_USE, keys_set[p]);
      write_reg(CFG_DISCARD, disc_set[p]);
      start = n_sent;
      while (n_sent - start < 168) random_txn();
    end
    quiesce();
    if (errors == 0 && read_data_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
